[design/blit_region_clipper_assert.svh]
`ifndef BLIT_REGION_CLIPPER_ASSERT_SVH
`define BLIT_REGION_CLIPPER_ASSERT_SVH

// same-cycle implication, checked out of reset
`define BRC_ASSERT_NOW(label, clk, rst_n, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define BRC_ASSERT_NEXT(label, clk, rst_n, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error(msg);

`endif

[design/brc_pkg.sv]
package brc_pkg;

  // largest frame or rectangle dimension
  localparam int MAX_DIM = 8192;
  localparam int DIM_W   = 14;
  localparam int POS_W   = 13;
  localparam int COORD_W = 16;
  localparam int CFG_IDX_W = 3;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_STITCH   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IN_WIDTH  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_IN_HEIGHT = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_OUT_WIDTH  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_OUT_HEIGHT = 3'd4;

  // reset frame size
  localparam logic [DIM_W-1:0] RST_WIDTH  = 14'd1920;
  localparam logic [DIM_W-1:0] RST_HEIGHT = 14'd1080;

  // one incoming rectangle pair
  typedef struct packed {
    logic signed [DIM_W-1:0] src_left;
    logic signed [DIM_W-1:0] src_top;
    logic [DIM_W-1:0]        src_width;
    logic [DIM_W-1:0]        src_height;
    logic [POS_W-1:0]        dst_left;
    logic [POS_W-1:0]        dst_top;
    logic [DIM_W-1:0]        dst_width;
    logic [DIM_W-1:0]        dst_height;
  } item_t;

  // active configuration, dimensions already saturated
  typedef struct packed {
    logic             keep;
    logic [DIM_W-1:0] iw;
    logic [DIM_W-1:0] ih;
    logic [DIM_W-1:0] ow;
    logic [DIM_W-1:0] oh;
  } cfg_t;

  // stage 1: saturated sizes, clipped origin, far edges
  typedef struct packed {
    logic signed [DIM_W-1:0]   sl;
    logic signed [DIM_W-1:0]   st;
    logic [POS_W-1:0]          cl;
    logic [POS_W-1:0]          ct;
    logic [DIM_W-1:0]          sw;
    logic [DIM_W-1:0]          sh;
    logic [DIM_W-1:0]          dw;
    logic [DIM_W-1:0]          dh;
    logic [POS_W-1:0]          dl;
    logic [POS_W-1:0]          dt;
    logic signed [COORD_W-1:0] se;
    logic signed [COORD_W-1:0] te;
    logic signed [COORD_W-1:0] od;
    logic signed [COORD_W-1:0] odv;
  } prep_t;

  // stage 2: clipped source extent
  typedef struct packed {
    logic signed [DIM_W-1:0]   sl;
    logic signed [DIM_W-1:0]   st;
    logic [POS_W-1:0]          cl;
    logic [POS_W-1:0]          ct;
    logic [DIM_W-1:0]          sw;
    logic [DIM_W-1:0]          sh;
    logic [DIM_W-1:0]          dw;
    logic [DIM_W-1:0]          dh;
    logic [POS_W-1:0]          dl;
    logic [POS_W-1:0]          dt;
    logic signed [COORD_W-1:0] w;
    logic signed [COORD_W-1:0] h;
    logic signed [COORD_W-1:0] od;
    logic signed [COORD_W-1:0] odv;
  } span_t;

  // stage 3: final rectangles in top-down form
  typedef struct packed {
    logic                      ok;
    logic signed [COORD_W-1:0] x0;
    logic signed [DIM_W-1:0]   top;
    logic [DIM_W-1:0]          sw;
    logic [DIM_W-1:0]          sh;
    logic [POS_W-1:0]          dl;
    logic [POS_W-1:0]          dt;
    logic [DIM_W-1:0]          dw;
    logic [DIM_W-1:0]          dh;
  } rect_t;

  // result word
  typedef struct packed {
    logic signed [COORD_W-1:0] src_x0;
    logic signed [COORD_W-1:0] src_y0;
    logic signed [COORD_W-1:0] src_x1;
    logic signed [COORD_W-1:0] src_y1;
    logic signed [COORD_W-1:0] dst_x0;
    logic signed [COORD_W-1:0] dst_y0;
    logic signed [COORD_W-1:0] dst_x1;
    logic signed [COORD_W-1:0] dst_y1;
    logic                      ok;
  } res_t;

  // saturate a dimension to the largest frame size
  function automatic logic [DIM_W-1:0] dim_sat(input logic [DIM_W-1:0] v);
    return (v > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : v;
  endfunction

  // signed minimum
  function automatic logic signed [COORD_W-1:0] smin(input logic signed [COORD_W-1:0] a,
                                                     input logic signed [COORD_W-1:0] b);
    return (a < b) ? a : b;
  endfunction

endpackage

[design/brc_in_if.sv]
interface brc_in_if;
  logic               valid;
  logic               ready;
  logic signed [13:0] src_left;
  logic signed [13:0] src_top;
  logic [13:0]        src_width;
  logic [13:0]        src_height;
  logic [12:0]        dst_left;
  logic [12:0]        dst_top;
  logic [13:0]        dst_width;
  logic [13:0]        dst_height;

  modport source (output valid, src_left, src_top, src_width, src_height,
                  dst_left, dst_top, dst_width, dst_height, input ready);
  modport sink (input valid, src_left, src_top, src_width, src_height,
                dst_left, dst_top, dst_width, dst_height, output ready);
endinterface

[design/brc_out_if.sv]
interface brc_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] blit_src_x0;
  logic signed [15:0] blit_src_y0;
  logic signed [15:0] blit_src_x1;
  logic signed [15:0] blit_src_y1;
  logic signed [15:0] blit_dst_x0;
  logic signed [15:0] blit_dst_y0;
  logic signed [15:0] blit_dst_x1;
  logic signed [15:0] blit_dst_y1;
  logic               blit_valid;

  modport source (output valid, blit_src_x0, blit_src_y0, blit_src_x1, blit_src_y1,
                  blit_dst_x0, blit_dst_y0, blit_dst_x1, blit_dst_y1, blit_valid,
                  input ready);
  modport sink (input valid, blit_src_x0, blit_src_y0, blit_src_x1, blit_src_y1,
                blit_dst_x0, blit_dst_y0, blit_dst_x1, blit_dst_y1, blit_valid,
                output ready);
endinterface

[design/brc_cfg_if.sv]
interface brc_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [13:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

[design/brc_prep.sv]
module brc_prep (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           adv,
  input  logic           in_vld,
  input  brc_pkg::item_t in_item,
  input  brc_pkg::cfg_t  cfg,
  output logic           vld_r,
  output brc_pkg::prep_t prep_r
);
  import brc_pkg::*;

  prep_t prep_nxt;

  // saturate sizes, clamp origin to the frame, form far edges
  always_comb begin
    prep_nxt.sl  = in_item.src_left;
    prep_nxt.st  = in_item.src_top;
    prep_nxt.cl  = in_item.src_left[DIM_W-1] ? '0 : in_item.src_left[POS_W-1:0];
    prep_nxt.ct  = in_item.src_top[DIM_W-1] ? '0 : in_item.src_top[POS_W-1:0];
    prep_nxt.sw  = dim_sat(in_item.src_width);
    prep_nxt.sh  = dim_sat(in_item.src_height);
    prep_nxt.dw  = dim_sat(in_item.dst_width);
    prep_nxt.dh  = dim_sat(in_item.dst_height);
    prep_nxt.dl  = in_item.dst_left;
    prep_nxt.dt  = in_item.dst_top;
    prep_nxt.se  = $signed({{2{in_item.src_left[DIM_W-1]}}, in_item.src_left})
                 + $signed({2'b00, prep_nxt.sw});
    prep_nxt.te  = $signed({{2{in_item.src_top[DIM_W-1]}}, in_item.src_top})
                 + $signed({2'b00, prep_nxt.sh});
    // room left in the output frame right of and below the anchor
    prep_nxt.od  = $signed({2'b00, cfg.ow}) - $signed({3'b000, in_item.dst_left});
    prep_nxt.odv = $signed({2'b00, cfg.oh}) - $signed({3'b000, in_item.dst_top});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (adv) begin
      vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      prep_r <= prep_nxt;
    end
  end

endmodule

[design/brc_clip.sv]
module brc_clip (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           adv,
  input  logic           in_vld,
  input  brc_pkg::prep_t prep,
  input  brc_pkg::cfg_t  cfg,
  output logic           vld_r,
  output brc_pkg::rect_t rect_r
);
  import brc_pkg::*;

  span_t span_nxt, span_r;
  rect_t rect_nxt;
  logic  span_vld_r;
  logic signed [COORD_W-1:0] fw, fh;

  // clip the source to the input frame
  always_comb begin
    span_nxt.sl  = prep.sl;
    span_nxt.st  = prep.st;
    span_nxt.cl  = prep.cl;
    span_nxt.ct  = prep.ct;
    span_nxt.sw  = prep.sw;
    span_nxt.sh  = prep.sh;
    span_nxt.dw  = prep.dw;
    span_nxt.dh  = prep.dh;
    span_nxt.dl  = prep.dl;
    span_nxt.dt  = prep.dt;
    span_nxt.od  = prep.od;
    span_nxt.odv = prep.odv;
    span_nxt.w   = smin(prep.se, $signed({2'b00, cfg.iw})) - $signed({3'b000, prep.cl});
    span_nxt.h   = smin(prep.te, $signed({2'b00, cfg.ih})) - $signed({3'b000, prep.ct});
  end

  // in keep-size mode clip to the target and to the output frame; pick the mode
  always_comb begin
    fw = smin(smin(span_r.w, $signed({2'b00, span_r.dw})), span_r.od);
    fh = smin(smin(span_r.h, $signed({2'b00, span_r.dh})), span_r.odv);
    rect_nxt.dl = span_r.dl;
    rect_nxt.dt = span_r.dt;
    if (cfg.keep) begin
      rect_nxt.ok  = (fw > 16'sd0) && (fh > 16'sd0);
      rect_nxt.x0  = $signed({3'b000, span_r.cl});
      rect_nxt.top = $signed({1'b0, span_r.ct});
      rect_nxt.sw  = fw[DIM_W-1:0];
      rect_nxt.sh  = fh[DIM_W-1:0];
      rect_nxt.dw  = fw[DIM_W-1:0];
      rect_nxt.dh  = fh[DIM_W-1:0];
    end else begin
      rect_nxt.ok  = (|span_r.sw) && (|span_r.sh) && (|span_r.dw) && (|span_r.dh);
      rect_nxt.x0  = $signed({{2{span_r.sl[DIM_W-1]}}, span_r.sl});
      rect_nxt.top = span_r.st;
      rect_nxt.sw  = span_r.sw;
      rect_nxt.sh  = span_r.sh;
      rect_nxt.dw  = span_r.dw;
      rect_nxt.dh  = span_r.dh;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      span_vld_r <= 1'b0;
      vld_r      <= 1'b0;
    end else if (adv) begin
      span_vld_r <= in_vld;
      vld_r      <= span_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      span_r <= span_nxt;
      rect_r <= rect_nxt;
    end
  end

endmodule

[design/brc_flip.sv]
module brc_flip (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           adv,
  input  logic           in_vld,
  input  brc_pkg::rect_t rect,
  input  brc_pkg::cfg_t  cfg,
  output logic           vld_r,
  output brc_pkg::res_t  res_r
);
  import brc_pkg::*;

  res_t res_nxt;
  logic signed [COORD_W-1:0] top_x, bot_s, bot_d, dl_x, dt_x, ih_x, oh_x;

  // right edges and bottom-up y, zero for a skipped blit
  always_comb begin
    top_x = $signed({{2{rect.top[DIM_W-1]}}, rect.top});
    bot_s = top_x + $signed({2'b00, rect.sh});
    dl_x  = $signed({3'b000, rect.dl});
    dt_x  = $signed({3'b000, rect.dt});
    bot_d = dt_x + $signed({2'b00, rect.dh});
    ih_x  = $signed({2'b00, cfg.ih});
    oh_x  = $signed({2'b00, cfg.oh});
    res_nxt = '0;
    if (rect.ok) begin
      res_nxt.ok     = 1'b1;
      res_nxt.src_x0 = rect.x0;
      res_nxt.src_x1 = rect.x0 + $signed({2'b00, rect.sw});
      res_nxt.src_y0 = ih_x - bot_s;
      res_nxt.src_y1 = ih_x - top_x;
      res_nxt.dst_x0 = dl_x;
      res_nxt.dst_x1 = dl_x + $signed({2'b00, rect.dw});
      res_nxt.dst_y0 = oh_x - bot_d;
      res_nxt.dst_y1 = oh_x - dt_x;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (adv) begin
      vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      res_r <= res_nxt;
    end
  end

endmodule

[design/blit_region_clipper.sv]
// Blit region clipper: turns one source/target rectangle pair per word into the
// coordinates of a 2D copy, either passing both rectangles through for a scaled
// copy or, in keep-size mode, clipping the source to the input frame and placing
// it at the target's top-left corner clipped to target and output frame. Y comes
// out bottom-up. A new word is taken every cycle unless the result side stalls;
// each word passes prepare, frame clip, target clip and y flip into the output
// register; a result-side stall holds the whole pipeline in place. Configuration
// writes are taken at once and must only come while the block is empty.
`include "blit_region_clipper_assert.svh"

module blit_region_clipper (
  input  logic clk,
  input  logic rst_n,
  brc_in_if.sink    in_chan,
  brc_out_if.source out_chan,
  brc_cfg_if.sink   cfg_chan
);
  import brc_pkg::*;

  cfg_t  cfg_r;
  item_t item;
  prep_t prep;
  rect_t rect;
  res_t  res;
  logic  adv, prep_vld, rect_vld, out_vld;

  // configuration registers, dimensions saturated on write
  assign cfg_chan.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.keep <= 1'b0;
      cfg_r.iw   <= RST_WIDTH;
      cfg_r.ih   <= RST_HEIGHT;
      cfg_r.ow   <= RST_WIDTH;
      cfg_r.oh   <= RST_HEIGHT;
    end else if (cfg_chan.valid) begin
      unique case (cfg_chan.index)
        CFG_STITCH:     cfg_r.keep <= cfg_chan.data[0];
        CFG_IN_WIDTH:   cfg_r.iw   <= dim_sat(cfg_chan.data);
        CFG_IN_HEIGHT:  cfg_r.ih   <= dim_sat(cfg_chan.data);
        CFG_OUT_WIDTH:  cfg_r.ow   <= dim_sat(cfg_chan.data);
        CFG_OUT_HEIGHT: cfg_r.oh   <= dim_sat(cfg_chan.data);
        default: ;
      endcase
    end
  end

  // pipeline moves whenever the output register is free or being taken
  assign adv           = !out_vld || out_chan.ready;
  assign in_chan.ready = adv;

  assign item.src_left   = in_chan.src_left;
  assign item.src_top    = in_chan.src_top;
  assign item.src_width  = in_chan.src_width;
  assign item.src_height = in_chan.src_height;
  assign item.dst_left   = in_chan.dst_left;
  assign item.dst_top    = in_chan.dst_top;
  assign item.dst_width  = in_chan.dst_width;
  assign item.dst_height = in_chan.dst_height;

  brc_prep u_prep (
    .clk     (clk),
    .rst_n   (rst_n),
    .adv     (adv),
    .in_vld  (in_chan.valid),
    .in_item (item),
    .cfg     (cfg_r),
    .vld_r   (prep_vld),
    .prep_r  (prep)
  );

  brc_clip u_clip (
    .clk    (clk),
    .rst_n  (rst_n),
    .adv    (adv),
    .in_vld (prep_vld),
    .prep   (prep),
    .cfg    (cfg_r),
    .vld_r  (rect_vld),
    .rect_r (rect)
  );

  brc_flip u_flip (
    .clk    (clk),
    .rst_n  (rst_n),
    .adv    (adv),
    .in_vld (rect_vld),
    .rect   (rect),
    .cfg    (cfg_r),
    .vld_r  (out_vld),
    .res_r  (res)
  );

  // result word
  assign out_chan.valid       = out_vld;
  assign out_chan.blit_src_x0 = res.src_x0;
  assign out_chan.blit_src_y0 = res.src_y0;
  assign out_chan.blit_src_x1 = res.src_x1;
  assign out_chan.blit_src_y1 = res.src_y1;
  assign out_chan.blit_dst_x0 = res.dst_x0;
  assign out_chan.blit_dst_y0 = res.dst_y0;
  assign out_chan.blit_dst_x1 = res.dst_x1;
  assign out_chan.blit_dst_y1 = res.dst_y1;
  assign out_chan.blit_valid  = res.ok;

  // checks
  `BRC_ASSERT_NOW(a_skip_zero, clk, rst_n, out_vld && !res.ok,
    res.src_x0 == 16'sd0 && res.src_x1 == 16'sd0 && res.dst_x0 == 16'sd0 && res.dst_y1 == 16'sd0,
    "skipped blit carries nonzero coordinates")
  `BRC_ASSERT_NOW(a_dst_nonempty, clk, rst_n, out_vld && res.ok,
    res.dst_x1 > res.dst_x0 && res.dst_y1 > res.dst_y0,
    "valid blit has an empty destination")
  `BRC_ASSERT_NEXT(a_accept_enters, clk, rst_n, in_chan.valid && in_chan.ready, prep_vld,
    "accepted word did not enter the pipeline")
  `BRC_ASSERT_NEXT(a_last_stage_moves, clk, rst_n, rect_vld && adv, out_vld,
    "word lost between clip and output stage")

endmodule
